### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers shared by the packet splitter queue and back end
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define HGPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// antecedent implies consequent on the next clock edge
`define HGPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/hgps_pkg.sv
// ----------------------------------------------------------------------------
// hgps_pkg
// types and constants of the h263 group of blocks packet splitter
// ----------------------------------------------------------------------------
package hgps_pkg;

    localparam int POS_W       = 24;
    localparam int LIMIT_W     = 12;
    localparam int SRC_W       = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int START_W     = 21;
    localparam int SIZE_W      = 13;
    localparam int BYTE_SPAN_W = POS_W - 2;
    localparam int SIZE_MAX    = 8191;
    localparam int Q_DEPTH     = 4;
    localparam int Q_ADDR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(988);
    localparam logic [SRC_W-1:0]   SRC_RESET   = SRC_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAYLOAD_LIMIT = 2'd0,
        CFG_SOURCE_FORMAT = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [POS_W-1:0] bit_position;
        logic             first_boundary;
        logic             end_boundary;
        logic             is_keyframe;
    } t_in_item;

    typedef struct packed {
        logic [START_W-1:0] start_byte;
        logic [SIZE_W-1:0]  size_bytes;
        logic [2:0]         start_skip_bits;
        logic [2:0]         end_skip_bits;
        logic [31:0]        header_word;
        logic               oversize;
        logic               last_of_group;
    } t_out_item;

    typedef struct packed {
        logic [POS_W-1:0] start_bit;
        logic [POS_W-1:0] cut_bit;
        logic             over;
        logic             last;
        logic             inter;
    } t_pkt;

    typedef struct packed {
        logic [1:0] cnt;
        t_pkt       pkt0;
        t_pkt       pkt1;
    } t_push;

endpackage

### hdl/hgps_front.sv
// ----------------------------------------------------------------------------
// hgps_front
// tracks open packet start and best cut, turns each boundary into packets
// ----------------------------------------------------------------------------
module hgps_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  hgps_pkg::t_in_item             i_item,
    input  logic [hgps_pkg::LIMIT_W-1:0]   i_limit,
    output hgps_pkg::t_push                o_push
);

    localparam int PW = hgps_pkg::POS_W;

    logic [PW-1:0] r_start, n_start;
    logic [PW-1:0] r_best,  n_best;
    logic          r_inter, n_inter;

    logic [PW:0]   lhs, rhs_s, rhs_b;
    logic          gt_s, gt_b, fit_s, fit_b, pend;
    logic          e1, e2, e3, gt1, fit1;
    logic [PW-1:0] s1, b1, s2, b2;
    logic [PW-1:0] pos;
    hgps_pkg::t_pkt pk1, pk2, pk3;
    hgps_pkg::t_push push;

    assign pos   = i_item.bit_position;
    assign lhs   = {1'b0, pos} + (PW+1)'(8);
    assign rhs_s = {1'b0, r_start} + (PW+1)'({i_limit, 3'b000});
    assign rhs_b = {1'b0, r_best} + (PW+1)'({i_limit, 3'b000});
    assign fit_s = lhs < rhs_s;
    assign fit_b = lhs < rhs_b;
    assign gt_s  = pos > r_start;
    assign gt_b  = pos > r_best;
    assign pend  = r_best != r_start;

    always_comb begin
        e1   = gt_s && !fit_s && pend;
        s1   = e1 ? r_best : r_start;
        b1   = r_best;
        gt1  = e1 ? gt_b : gt_s;
        fit1 = e1 ? fit_b : fit_s;
        e2   = gt1 && !fit1;
        s2   = s1;
        b2   = b1;
        if (e2) begin
            s2 = pos;
            b2 = pos;
        end else if (gt1) begin
            b2 = pos;
        end
        e3 = i_item.end_boundary && (b2 != s2);

        pk1 = '{start_bit: r_start, cut_bit: r_best, over: 1'b0, last: 1'b0,
                inter: r_inter};
        pk2 = '{start_bit: s1, cut_bit: pos, over: 1'b1, last: 1'b0, inter: r_inter};
        pk3 = '{start_bit: s2, cut_bit: b2, over: 1'b0, last: 1'b0, inter: r_inter};

        push = '0;
        if (e1) begin
            push.pkt0      = pk1;
            push.pkt1      = e2 ? pk2 : pk3;
            push.pkt0.last = i_item.end_boundary && !(e2 || e3);
            push.pkt1.last = i_item.end_boundary;
            push.cnt       = (e2 || e3) ? 2'd2 : 2'd1;
        end else begin
            push.pkt0      = e2 ? pk2 : pk3;
            push.pkt0.last = i_item.end_boundary;
            push.pkt1      = pk3;
            push.cnt       = (e2 || e3) ? 2'd1 : 2'd0;
        end

        n_start = r_start;
        n_best  = r_best;
        n_inter = r_inter;
        if (i_accept) begin
            if (i_item.first_boundary) begin
                n_start = pos;
                n_best  = pos;
                n_inter = !i_item.is_keyframe;
            end else begin
                n_start = e3 ? b2 : s2;
                n_best  = b2;
            end
        end
        if (!i_accept || i_item.first_boundary) begin
            push.cnt = 2'd0;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_best  <= '0;
            r_inter <= 1'b0;
        end else begin
            r_start <= n_start;
            r_best  <= n_best;
            r_inter <= n_inter;
        end
    end

endmodule

### hdl/hgps_queue.sv
// ----------------------------------------------------------------------------
// hgps_queue
// small packet queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hgps_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hgps_pkg::t_push i_push,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_nonempty,
    output hgps_pkg::t_pkt  o_head
);

    localparam int AW = hgps_pkg::Q_ADDR_W;
    localparam int CW = hgps_pkg::Q_CNT_W;

    hgps_pkg::t_pkt r_mem [hgps_pkg::Q_DEPTH];
    logic [AW-1:0]  r_wr, n_wr;
    logic [AW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [AW-1:0]  wr_next;

    assign wr_next    = r_wr + AW'(1);
    assign o_nonempty = r_cnt != '0;
    assign o_full     = r_cnt > CW'(hgps_pkg::Q_DEPTH - 2);
    assign o_head     = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr + AW'(i_push.cnt);
        n_rd  = r_rd + AW'(i_pop);
        n_cnt = r_cnt + CW'(i_push.cnt) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.pkt0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_next] <= i_push.pkt1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    `HGPS_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(hgps_pkg::Q_DEPTH), "queue overflow")
    `HGPS_ASSERT(a_pop_nonempty, i_clk, i_rst_n, !i_pop || o_nonempty, "pop from empty queue")
    `HGPS_ASSERT(a_push_room, i_clk, i_rst_n, !o_full || i_push.cnt == 2'd0, "push when full")

endmodule

### hdl/hgps_back.sv
// ----------------------------------------------------------------------------
// hgps_back
// formats queued packets into descriptors and holds the output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hgps_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_nonempty,
    input  hgps_pkg::t_pkt               i_head,
    input  logic [hgps_pkg::SRC_W-1:0]   i_src,
    input  logic                         i_stall,
    output logic                         o_pop,
    output logic                         o_valid,
    output hgps_pkg::t_out_item          o_data
);

    localparam int PW = hgps_pkg::POS_W;
    localparam int BW = hgps_pkg::BYTE_SPAN_W;

    logic                r_valid;
    hgps_pkg::t_out_item r_data, n_data;
    logic [PW:0]         cut_up;
    logic [BW-1:0]       diff;
    logic [2:0]          sbit, ebit;
    logic [PW-1:0]       cut_m1;

    assign o_pop  = i_nonempty && (!r_valid || !i_stall);
    assign cut_up = {1'b0, i_head.cut_bit} + (PW+1)'(7);
    assign diff   = BW'(cut_up >> 3) - BW'(i_head.start_bit >> 3);
    assign cut_m1 = i_head.cut_bit - PW'(1);
    assign sbit   = i_head.start_bit[2:0];
    assign ebit   = ~cut_m1[2:0];

    always_comb begin
        n_data.start_byte      = hgps_pkg::START_W'(i_head.start_bit >> 3);
        n_data.size_bytes      = (diff > BW'(hgps_pkg::SIZE_MAX)) ?
                                 hgps_pkg::SIZE_W'(hgps_pkg::SIZE_MAX) :
                                 hgps_pkg::SIZE_W'(diff);
        n_data.start_skip_bits = sbit;
        n_data.end_skip_bits   = ebit;
        n_data.header_word     = {2'b00, sbit, ebit, i_src, i_head.inter, 20'd0};
        n_data.oversize        = i_head.over;
        n_data.last_of_group   = i_head.last;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_nonempty;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    `HGPS_ASSERT(a_size_nonzero, i_clk, i_rst_n, !r_valid || r_data.size_bytes != '0, "empty packet")
    `HGPS_ASSERT_NEXT(a_pop_loads, i_clk, i_rst_n, o_pop, r_valid, "popped packet not shown")

endmodule

### hdl/h263_gob_packet_splitter.sv
// ----------------------------------------------------------------------------
// h263_gob_packet_splitter
// splits one h263 group of blocks into mode a packet descriptors
// ----------------------------------------------------------------------------
// input channel: i_valid / o_stall / i_data, one macroblock boundary per word,
// first boundary of the group first, the group's end position last.
// output channel: o_valid / i_stall / o_data, one packet descriptor per word.
// configuration: i_cfg_we / i_cfg_idx / i_cfg_data, index 0 is the payload
// limit in bytes, index 1 the source format code; write only while idle.
// one boundary word is taken every cycle while o_stall is low; a word makes
// zero, one or two descriptors, which are written into a four-entry queue and
// then popped into the output register.
// the output side delivers at most one descriptor per cycle, so the second
// descriptor of a boundary that makes two waits in the queue behind the first.
// o_stall rises when the queue holds more than two packets.
// when i_stall is high the output word holds and the queue fills behind it.
// reset empties the queue and output register, clears packet start, best
// cut and inter flag, and loads limit 988 and source format 1.
// ----------------------------------------------------------------------------
module h263_gob_packet_splitter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  hgps_pkg::t_in_item                i_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output hgps_pkg::t_out_item               o_data,
    input  logic                              i_cfg_we,
    input  logic [hgps_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hgps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [hgps_pkg::LIMIT_W-1:0] r_limit;
    logic [hgps_pkg::SRC_W-1:0]   r_src;
    logic                         accept;
    logic                         full;
    logic                         nonempty;
    logic                         pop;
    hgps_pkg::t_push              push;
    hgps_pkg::t_pkt               head;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= hgps_pkg::LIMIT_RESET;
            r_src   <= hgps_pkg::SRC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hgps_pkg::CFG_PAYLOAD_LIMIT: begin
                    r_limit <= i_cfg_data[hgps_pkg::LIMIT_W-1:0];
                end
                hgps_pkg::CFG_SOURCE_FORMAT: begin
                    r_src <= i_cfg_data[hgps_pkg::SRC_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    hgps_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_data),
        .i_limit  (r_limit),
        .o_push   (push)
    );

    hgps_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_pop      (pop),
        .o_full     (full),
        .o_nonempty (nonempty),
        .o_head     (head)
    );

    hgps_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (nonempty),
        .i_head     (head),
        .i_src      (r_src),
        .i_stall    (i_stall),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_data     (o_data)
    );

endmodule
